// ----- rtl/opm_pkg.sv -----
// ----------------------------------------------------------------------------
// opm_pkg
// Shared constants, codes and types of the one-mismatch pattern matcher.
// ----------------------------------------------------------------------------
package opm_pkg;

    localparam int PAT_MAX  = 64;
    localparam int SEL_W    = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int POS_W    = 20;
    localparam int START_W  = 20;
    localparam int LEN_W    = 7;
    localparam int SYM_W    = 8;
    localparam int IDX_W    = 6;
    localparam int ACT_W    = 2;
    localparam int CNT_W    = 2;
    localparam int S_DATA_W = ((SYM_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((START_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(2);

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_TEXT    = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef struct packed {
        logic load;   // write this cell's pattern byte
        logic shift;  // text byte: take neighbor count plus own compare
        logic clear;  // restart: zero the count
        logic tap;    // this cell ends the window of the current length
    } cell_ctrl_t;

endpackage

// ----- rtl/opm_cell.sv -----
// ----------------------------------------------------------------------------
// opm_cell
// One cell of the matcher row: a pattern byte and the saturating mismatch
// count of one partial alignment, passed on to the next cell per text byte.
// ----------------------------------------------------------------------------
module opm_cell
    import opm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  logic [SYM_W-1:0] sym,
    input  logic [CNT_W-1:0] cnt_in,
    output logic [CNT_W-1:0] cnt_out,
    output logic [CNT_W-1:0] tap_out
);

    logic [SYM_W-1:0] pat_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W:0]   sum;
    logic             miss;

    assign miss = (sym != pat_reg);
    assign sum  = {1'b0, cnt_in} + (CNT_W+1)'(miss);

    always_comb begin
        if (ctrl.clear) begin
            cnt_next = '0;
        end else if (ctrl.shift) begin
            cnt_next = (sum > {1'b0, CNT_SAT}) ? CNT_SAT : sum[CNT_W-1:0];
        end else begin
            cnt_next = cnt_reg;
        end
    end

    // pattern byte is undefined until loaded
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            pat_reg <= sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt_out = cnt_reg;
    assign tap_out = ctrl.tap ? cnt_reg : '0;

endmodule

// ----- rtl/one_mismatch_pattern_matcher.sv -----
// ----------------------------------------------------------------------------
// one_mismatch_pattern_matcher
// Streams text bytes past a row of cells holding the pattern; reports every
// window that differs from the pattern in at most one byte.
// ----------------------------------------------------------------------------
// channel | dir | tdata / data               | tuser
// s_      | in  | [7:0] symbol, [13:8] index | [1:0] action
// m_      | out | [19:0] start_position      | exact
// cfg_    | in  | [6:0] pattern_length       | -
//
// A text request updates the cell row when it is accepted; the window count at the
// current length is then tapped and registered into the output register.
// A new request enters while the previous one sits in the output register,
// so the row sustains one request per cycle while m_tready stays high.
// Reset clears counts, text position and length (to 1); pattern bytes are
// undefined until loaded. A stalled output keeps one result and one more request.
// ----------------------------------------------------------------------------
module one_mismatch_pattern_matcher
    import opm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // symbol, index, zero pad
    input  logic [ACT_W-1:0]    s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // start_position, zero pad
    output logic                m_tuser,   // exact
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data
);

    logic [LEN_W-1:0]   len_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               pending_reg, pending_next;
    logic               m_valid_reg, m_valid_next;
    logic [START_W-1:0] m_start_reg;
    logic               m_exact_reg;

    logic [SYM_W-1:0]   sym;
    logic [IDX_W-1:0]   idx;
    action_t            act;
    logic               s_acc, is_load, is_text, is_restart, advance, hit;
    logic [SEL_W-1:0]   last_idx;
    logic [POS_W-1:0]   eff_len;
    logic [CNT_W-1:0]   win_cnt;

    cell_ctrl_t         ctrl [PAT_MAX];
    logic [CNT_W-1:0]   cnt  [PAT_MAX];
    logic [CNT_W-1:0]   tap  [PAT_MAX];

    assign sym = s_tdata[SYM_W-1:0];
    assign idx = s_tdata[SYM_W+IDX_W-1:SYM_W];
    assign act = action_t'(s_tuser);

    assign s_acc      = s_tvalid && s_tready;
    assign is_load    = s_acc && (act == ACT_LOAD);
    assign is_text    = s_acc && (act == ACT_TEXT);
    assign is_restart = s_acc && (act == ACT_RESTART);

    assign advance   = pending_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !pending_reg || advance;
    assign cfg_ready = 1'b1;

    // length 0 acts as 1, lengths past the row act as the full row
    always_comb begin
        if (len_reg == '0) begin
            last_idx = '0;
        end else if (32'(len_reg) > 32'(PAT_MAX)) begin
            last_idx = SEL_W'(PAT_MAX - 1);
        end else begin
            last_idx = SEL_W'(len_reg - 1'b1);
        end
    end
    assign eff_len = POS_W'(32'(last_idx) + 1);

    genvar j;
    generate
        for (j = 0; j < PAT_MAX; j++) begin : g_cell
            assign ctrl[j].load  = is_load && (32'(idx) == j);
            assign ctrl[j].shift = is_text;
            assign ctrl[j].clear = is_restart;
            assign ctrl[j].tap   = (32'(last_idx) == j);

            if (j == 0) begin : g_head
                opm_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctrl    (ctrl[j]),
                    .sym     (sym),
                    .cnt_in  ({CNT_W{1'b0}}),
                    .cnt_out (cnt[j]),
                    .tap_out (tap[j])
                );
            end else begin : g_body
                opm_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .ctrl    (ctrl[j]),
                    .sym     (sym),
                    .cnt_in  (cnt[j-1]),
                    .cnt_out (cnt[j]),
                    .tap_out (tap[j])
                );
            end
        end
    endgenerate

    // one-hot tap: only the cell ending the window drives a nonzero value
    always_comb begin
        win_cnt = '0;
        for (int k = 0; k < PAT_MAX; k++) begin
            win_cnt = win_cnt | tap[k];
        end
    end

    assign hit = (pos_reg >= eff_len) && (win_cnt < CNT_SAT);

    always_comb begin
        pos_next = pos_reg;
        if (is_restart) begin
            pos_next = '0;
        end else if (is_text && (pos_reg != {POS_W{1'b1}})) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_comb begin
        pending_next = pending_reg;
        if (is_text) begin
            pending_next = 1'b1;
        end else if (advance) begin
            pending_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = hit;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_W'(1);
            pos_reg     <= '0;
            pending_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                len_reg <= cfg_data;
            end
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_start_reg <= START_W'(pos_reg - eff_len + 1'b1);
            m_exact_reg <= (win_cnt == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_start_reg);
    assign m_tuser  = m_exact_reg;

`ifndef NO_ASSERTIONS
    a_restart_clears_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        is_restart |=> (pos_reg == '0))
        else $error("text position not cleared by restart");

    a_start_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_start_reg != '0))
        else $error("result with zero start position");

    a_head_cell_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt[0] != CNT_SAT)
        else $error("first cell counted more than one mismatch");

    a_result_needs_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !pending_reg) |=> !m_valid_reg)
        else $error("result appeared without a pending request");
`endif

endmodule

// ----- test/opm_match_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opm_match_checker
// Watches the request, result and length channels of the one-mismatch
// pattern matcher, keeps its own row of window counts and compares every
// result, field by field, against the oldest predicted match.
// ----------------------------------------------------------------------------
module opm_match_checker
    import opm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // symbol, index, zero pad
    input  logic [ACT_W-1:0]    s_tuser,   // action
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // start_position, zero pad
    input  logic                m_tuser,   // exact
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [LEN_W-1:0]    cfg_data,
    output int                  err_count,
    output int                  pending
);

    typedef struct packed {
        logic [START_W-1:0] start_pos;
        logic               exact;
    } match_t;

    logic [SYM_W-1:0] pat_mem [PAT_MAX];
    logic [CNT_W-1:0] win_cnt [PAT_MAX];
    logic [POS_W-1:0] text_pos;
    logic [LEN_W-1:0] pat_len;
    match_t           expected_matches [$];
    int               errors = 0;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c, logic miss);
        if (miss && c != CNT_SAT) begin
            return c + 1'b1;
        end
        return c;
    endfunction

    // One text byte: shift every alignment one cell up, then tap the window.
    task automatic take_text(input logic [SYM_W-1:0] sym);
        int unsigned n;
        match_t      m;
        for (int j = PAT_MAX - 1; j > 0; j--) begin
            win_cnt[j] = bump(win_cnt[j-1], sym != pat_mem[j]);
        end
        win_cnt[0] = (sym != pat_mem[0]) ? CNT_W'(1) : CNT_W'(0);
        if (text_pos != {POS_W{1'b1}}) begin
            text_pos = text_pos + 1'b1;
        end
        n = (pat_len == 0) ? 1 : (pat_len > PAT_MAX) ? PAT_MAX : pat_len;
        if (text_pos >= n && win_cnt[n-1] <= 1) begin
            m.start_pos = START_W'(text_pos - n + 1);
            m.exact     = (win_cnt[n-1] == 0);
            expected_matches.insert(expected_matches.size(), m);
        end
    endtask

    always @(posedge aclk) begin
        match_t m;
        if (!aresetn) begin
            foreach (pat_mem[j]) pat_mem[j] = '0;
            foreach (win_cnt[j]) win_cnt[j] = '0;
            text_pos = '0;
            pat_len  = LEN_W'(1);
            expected_matches.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_matches.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected match: expected none, actual start %0d exact %0b",
                             $time, m_tdata[START_W-1:0], m_tuser);
                end else begin
                    m = expected_matches.pop_front();
                    if (m_tdata[START_W-1:0] !== m.start_pos) begin
                        errors++;
                        $display("%0t: start_position mismatch: expected %0d, actual %0d",
                                 $time, m.start_pos, m_tdata[START_W-1:0]);
                    end
                    if (m_tuser !== m.exact) begin
                        errors++;
                        $display("%0t: exact mismatch: expected %0b, actual %0b",
                                 $time, m.exact, m_tuser);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                pat_len = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    ACT_LOAD:    pat_mem[s_tdata[SYM_W +: IDX_W]] = s_tdata[SYM_W-1:0];
                    ACT_TEXT:    take_text(s_tdata[SYM_W-1:0]);
                    ACT_RESTART: begin
                        text_pos = '0;
                        foreach (win_cnt[j]) win_cnt[j] = '0;
                    end
                    default: ;  // unused action, ignored
                endcase
            end
        end
        err_count <= errors;
        pending   <= expected_matches.size();
    end

endmodule

// ----- test/one_mismatch_pattern_matcher_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_mismatch_pattern_matcher_tb
// Loads a pattern, streams text windows built from it with zero, one or two
// altered bytes plus random noise, across many pattern lengths, then a 64-byte
// window and two bytes at length one. Random gaps on both channels, one long
// output hold-off; the checker module predicts and compares every match.
// ----------------------------------------------------------------------------
module one_mismatch_pattern_matcher_tb
    import opm_pkg::*;
();

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WD_LIMIT   = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int RAND_ITEMS = 1400;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // symbol, index, zero pad
    logic [ACT_W-1:0]    s_tuser;   // action
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // start_position, zero pad
    logic                m_tuser;   // exact
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LEN_W-1:0]    cfg_data;

    int               err_count;
    int               pending;
    int               idle_cycles = 0;
    logic [SYM_W-1:0] pat_copy [PAT_MAX];
    bit               s_no_gaps   = 1'b0;
    bit               m_no_stalls = 1'b0;
    bit               hold_req    = 1'b0;

    one_mismatch_pattern_matcher DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    opm_match_checker checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .err_count (err_count),
        .pending   (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: cycles in which no channel moves a request.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (!m_no_stalls && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    task automatic send_req(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                            input logic [IDX_W-1:0] idx);
        int gap;
        gap = (s_no_gaps || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {{(S_DATA_W - SYM_W - IDX_W){1'b0}}, idx, sym};
        s_tuser  = act;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(input logic [SYM_W-1:0] sym);
        send_req(ACT_TEXT, sym, IDX_W'($urandom_range(0, PAT_MAX - 1)));
    endtask

    task automatic load_sym(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] sym);
        pat_copy[idx] = sym;
        send_req(ACT_LOAD, sym, idx);
    endtask

    // Pattern prefix of length n with up to two bytes altered.
    task automatic send_window(input int unsigned n, input int unsigned nmiss);
        int unsigned      p1;
        int unsigned      p2;
        logic [SYM_W-1:0] sym;
        p1 = (nmiss > 0) ? $urandom_range(0, n - 1) : n;
        p2 = (nmiss > 1) ? $urandom_range(0, n - 1) : n;
        for (int k = 0; k < n; k++) begin
            sym = pat_copy[k];
            if (k == p1 || k == p2) sym = sym ^ SYM_W'($urandom_range(1, 255));
            send_text(sym);
        end
    endtask

    // Length change only once all matches are out and the row has settled.
    task automatic write_len(input logic [LEN_W-1:0] len);
        @(negedge aclk);
        s_tvalid = 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = len;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int               item_cnt;
        int               phase;
        int               burst;
        int               r;
        int unsigned      n;
        logic [LEN_W-1:0] len;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // every pattern cell gets written before any text goes in
        for (int i = 0; i < PAT_MAX; i++) begin
            load_sym(IDX_W'(i), (i == 0) ? 8'h00 : (i == PAT_MAX - 1) ? 8'hFF :
                     SYM_W'($urandom_range(0, 255)));
        end

        // directed: reset length of one
        send_text(pat_copy[0]);
        send_text(pat_copy[0] ^ 8'h5A);
        send_req(ACT_UNUSED, 8'hFF, 6'h3F);
        send_req(ACT_RESTART, 8'h00, 6'h00);
        send_text(pat_copy[0]);

        write_len(7'd4);
        send_window(4, 0);
        send_window(4, 1);
        send_window(4, 2);
        // pattern change with windows still in flight
        load_sym(6'd2, ~pat_copy[2]);
        send_window(4, 0);

        // zero length acts as one
        write_len(7'd0);
        send_text(pat_copy[0]);

        item_cnt = 0;
        phase    = 0;
        while (item_cnt < RAND_ITEMS) begin
            phase++;
            r = $urandom_range(0, 9);
            case (r)
                0:       len = 7'd1;
                1:       len = 7'd64;
                2:       len = 7'd0;
                3:       len = 7'd127;
                4, 5, 6: len = LEN_W'($urandom_range(2, 8));
                default: len = LEN_W'($urandom_range(1, 127));
            endcase
            if (phase == 2) len = 7'd1;  // every text byte matches: fills the output
            write_len(len);
            n = (len == 0) ? 1 : (len > PAT_MAX) ? PAT_MAX : len;
            s_no_gaps   = ($urandom_range(0, 3) == 0);
            m_no_stalls = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                s_no_gaps = 1'b1;
                hold_req  = 1'b1;
            end
            if ($urandom_range(0, 1) == 0) begin
                send_req(ACT_RESTART, SYM_W'($urandom), IDX_W'($urandom));
                item_cnt++;
            end
            burst = 0;
            while (burst < 120 && item_cnt < RAND_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    send_window(n, $urandom_range(0, 2));
                    burst    += n;
                    item_cnt += n;
                end else if (r < 75) begin
                    send_text(SYM_W'($urandom));
                    burst++;
                    item_cnt++;
                end else if (r < 85) begin
                    load_sym(IDX_W'($urandom), SYM_W'($urandom));
                    burst++;
                    item_cnt++;
                end else if (r < 92) begin
                    send_req(ACT_RESTART, SYM_W'($urandom), IDX_W'($urandom));
                    burst++;
                    item_cnt++;
                end else begin
                    send_req(ACT_UNUSED, SYM_W'($urandom), IDX_W'($urandom));
                end
            end
        end

        // full-length window right after a restart
        write_len(7'd64);
        s_no_gaps   = 1'b1;
        m_no_stalls = 1'b1;
        send_req(ACT_RESTART, 8'h00, 6'h00);
        send_window(PAT_MAX, 0);
        write_len(7'd1);
        send_text(pat_copy[0]);
        send_text(~pat_copy[0]);

        @(negedge aclk);
        s_tvalid = 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (10) @(posedge aclk);
        if (err_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
